[hw/rtl/b2da_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII digit converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   // one BCD digit
   localparam int DIGIT_BITS = 4;
   // input bits folded into the BCD register per conversion cycle
   localparam int STEP_BITS  = 4;
   // width of one character beat
   localparam int CHAR_BITS  = 6;
   localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONV,
      FE_DONE
   } front_state_type;

endpackage

[hw/rtl/binary_to_decimal_ascii_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits
// Converts an unsigned binary value to its decimal ASCII digits, most
// significant first, leading zeros suppressed, last digit flagged.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | beat
//  ---------+-----------------------------------------+--------------------------
//  request  | req_valid, req_stall, req_value         | one binary value
//  response | rsp_valid, rsp_stall, rsp_digit_char,   | one ASCII digit; a value
//           | rsp_last_digit                          | gives 1..MAX_DIGITS beats
//
// Conversion feeds STEP_BITS input bits per step through the shift-add-3
// unit, then hands the digits to the queue; the front takes no new value
// until the last one is handed off. Digits leave one per cycle while rsp_stall
// is low. A two-entry queue lets conversion run ahead of a stalled output.
// Reset is synchronous and clears only control state.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [VALUE_BITS-1:0]          req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0] rsp_digit_char,
   output logic                           rsp_last_digit
);
   import b2da_pkg::*;

   localparam int ENTRY_W = MAX_DIGITS * DIGIT_BITS + $clog2(MAX_DIGITS);

   logic               push_valid;
   logic               push_stall;
   logic [ENTRY_W-1:0] push_data;
   logic               pop_valid;
   logic               pop_stall;
   logic [ENTRY_W-1:0] pop_data;

   b2da_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data)
   );

   b2da_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_data   (pop_data)
   );

   b2da_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_stall      (pop_stall),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

endmodule

[hw/rtl/b2da_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_front
// Accepts a binary value and converts it to BCD by shift-and-add-3, several
// input bits per cycle, then pushes the digits and the index of the leading
// nonzero digit into the queue.
// ----------------------------------------------------------------------------
module b2da_front #(
   parameter int VALUE_BITS = 32,
   parameter int MAX_DIGITS = 10
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_stall,
   input  logic [VALUE_BITS-1:0]                           req_value,
   output logic                                            push_valid,
   input  logic                                            push_stall,
   output logic [MAX_DIGITS*b2da_pkg::DIGIT_BITS+$clog2(MAX_DIGITS)-1:0] push_data
);
   import b2da_pkg::*;

   localparam int STEPS    = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_BITS = STEPS * STEP_BITS;
   localparam int CNT_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int BCD_BITS = MAX_DIGITS * DIGIT_BITS;
   localparam int PTR_W    = $clog2(MAX_DIGITS);

   front_state_type       state_ff, state_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [PAD_BITS-1:0]   shreg_ff, shreg_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [BCD_BITS-1:0]   bcd_step;
   logic [PAD_BITS-1:0]   shreg_step;
   logic [PTR_W-1:0]      top_idx;
   logic                  req_take;
   logic                  cnt_last;

   // STEP_BITS rounds of correct-then-shift
   always_comb begin
      bcd_step   = bcd_ff;
      shreg_step = shreg_ff;
      for (int i = 0; i < STEP_BITS; i++) begin
         for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_step[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
               bcd_step[d*DIGIT_BITS +: DIGIT_BITS] =
                  bcd_step[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
            end
         end
         // carry out of the top digit is dropped: result is mod 10^MAX_DIGITS
         bcd_step   = {bcd_step[BCD_BITS-2:0], shreg_step[PAD_BITS-1]};
         shreg_step = {shreg_step[PAD_BITS-2:0], 1'b0};
      end
   end

   // highest nonzero digit; zero when all digits are zero
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < MAX_DIGITS; d++) begin
         if (bcd_ff[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            top_idx = PTR_W'(d);
         end
      end
   end

   assign push_data = {top_idx, bcd_ff};
   assign cnt_last  = (cnt_ff == CNT_W'(STEPS - 1));
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      push_valid = 1'b0;
      unique case (state_ff)
         FE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = FE_CONV;
            end
         end
         FE_CONV: begin
            if (cnt_last) begin
               state_in = FE_DONE;
            end
         end
         FE_DONE: begin
            push_valid = 1'b1;
            // next beat may enter in the same cycle the result is pushed
            req_stall  = push_stall;
            if (!push_stall) begin
               state_in = req_valid ? FE_CONV : FE_IDLE;
            end
         end
         default: begin
            state_in = FE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      bcd_in   = bcd_ff;
      shreg_in = shreg_ff;
      cnt_in   = cnt_ff;
      if (req_take) begin
         bcd_in   = '0;
         shreg_in = PAD_BITS'(req_value);
         cnt_in   = '0;
      end else if (state_ff == FE_CONV) begin
         bcd_in   = bcd_step;
         shreg_in = shreg_step;
         cnt_in   = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      bcd_ff   <= bcd_in;
      shreg_ff <= shreg_in;
      cnt_ff   <= cnt_in;
   end

   a_take_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == FE_CONV)
      else $error("accepted beat did not start conversion");

   a_conv_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_CONV && cnt_last |=> state_ff == FE_DONE)
      else $error("conversion did not finish after the last step");

   a_no_take_in_conv: assert property (@(posedge clock) disable iff (reset)
      state_ff == FE_CONV |-> req_stall && !push_valid)
      else $error("front busy but open");

endmodule

[hw/rtl/b2da_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_queue
// Two-entry register queue between the converter and the digit emitter.
// ----------------------------------------------------------------------------
module b2da_queue #(
   parameter int WIDTH = 44
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output logic [WIDTH-1:0] pop_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push_take;
   logic             pop_take;

   assign push_stall = (count_ff == 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push_take  = push_valid && !push_stall;
   assign pop_take   = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push_take;
      rd_ptr_in = rd_ptr_ff ^ pop_take;
      count_in  = count_ff + {1'b0, push_take} - {1'b0, pop_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_take) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/b2da_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_back
// Emits the digits of one queued entry, most significant first, one beat
// per cycle while rsp_stall is low, flagging the least significant digit.
// ----------------------------------------------------------------------------
module b2da_back #(
   parameter int MAX_DIGITS = 10
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            pop_valid,
   output logic                                            pop_stall,
   input  logic [MAX_DIGITS*b2da_pkg::DIGIT_BITS+$clog2(MAX_DIGITS)-1:0] pop_data,
   output logic                                            rsp_valid,
   input  logic                                            rsp_stall,
   output logic [b2da_pkg::CHAR_BITS-1:0]                  rsp_digit_char,
   output logic                                            rsp_last_digit
);
   import b2da_pkg::*;

   localparam int BCD_BITS = MAX_DIGITS * DIGIT_BITS;
   localparam int PTR_W    = $clog2(MAX_DIGITS);

   logic                  busy_ff, busy_in;
   logic [BCD_BITS-1:0]   digits_ff, digits_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [DIGIT_BITS-1:0] cur_digit;
   logic                  rsp_take;
   logic                  pop_take;

   assign cur_digit      = digits_ff[ptr_ff*DIGIT_BITS +: DIGIT_BITS];
   assign rsp_valid      = busy_ff;
   assign rsp_last_digit = (ptr_ff == '0);
   assign rsp_digit_char = ASCII_ZERO + CHAR_BITS'(cur_digit);
   assign rsp_take       = rsp_valid && !rsp_stall;
   // load the next entry when idle or as the last digit leaves
   assign pop_stall      = busy_ff && !(rsp_take && rsp_last_digit);
   assign pop_take       = pop_valid && !pop_stall;

   always_comb begin
      busy_in   = busy_ff;
      digits_in = digits_ff;
      ptr_in    = ptr_ff;
      if (pop_take) begin
         busy_in   = 1'b1;
         digits_in = pop_data[BCD_BITS-1:0];
         ptr_in    = pop_data[BCD_BITS +: PTR_W];
      end else if (rsp_take) begin
         if (rsp_last_digit) begin
            busy_in = 1'b0;
         end else begin
            ptr_in = ptr_ff - PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ptr_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ptr_ff  <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
   end

   a_ptr_steps_down: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !rsp_last_digit |=> rsp_valid && ptr_ff == $past(ptr_ff) - PTR_W'(1))
      else $error("digit pointer did not step down");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_last_digit && !pop_valid |=> !rsp_valid)
      else $error("output still valid after the last digit with nothing queued");

   a_idle_loads: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && pop_valid |=> rsp_valid)
      else $error("idle emitter did not take a queued entry");

endmodule
